>>> hdl/awgs_pkg.sv
// Shared types and constants for the acoustic wave grid stepper.
// Holds the transaction structs, the cell memory word and the sequencer states.
// Depends on nothing.
`default_nettype none

package awgs_pkg;

  localparam int GRID_ROWS_DEF = 64;
  localparam int GRID_COLS_DEF = 64;

  localparam logic [5:0] SRC_ROW_RST = 6'd48;
  localparam logic [5:0] SRC_COL_RST = 6'd27;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic REG_SRC_ROW = 1'b0;
  localparam logic REG_SRC_COL = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         cell_row;
    logic [5:0]         cell_col;
    logic signed [31:0] current_value;
    logic signed [31:0] previous_value;
    logic [14:0]        courant_number;
    logic signed [31:0] source_amplitude;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               saturated;
  } rsp_t;

  // One word of the cell memory
  typedef struct packed {
    logic [14:0]        cour;
    logic signed [31:0] prev;
    logic signed [31:0] cur;
  } cell_t;

  // Operands for one cell update
  typedef struct packed {
    logic               is_edge;
    logic               is_src;
    logic signed [31:0] cur;
    logic signed [31:0] prev;
    logic [14:0]        cour;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic signed [31:0] v3;
    logic signed [31:0] v4;
  } calc_op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDWAIT,
    S_GATHER,
    S_LAUNCH,
    S_CALC,
    S_COPY,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

>>> hdl/awgs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none

module awgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/awgs_calc.sv
// Three-stage arithmetic pipeline for one cell update (interior or absorbing edge).
// Depends on awgs_pkg for the operand struct.
`default_nettype none

module awgs_calc import awgs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               op_valid,
  input  wire calc_op_t           op,
  input  wire logic signed [31:0] amp,
  output logic                    res_valid,
  output logic signed [31:0]      res_value,
  output logic                    res_sat
);

  logic                v1q;
  logic                is_edge1;
  logic                src1;
  logic [29:0]         mul1;
  logic signed [35:0]  term1;
  logic signed [33:0]  base1;
  logic [29:0]         mul1_next;
  logic signed [35:0]  term1_next;
  logic signed [33:0]  base1_next;

  logic                v2q;
  logic                src2;
  logic signed [50:0]  prod2;
  logic signed [33:0]  base2;
  logic [15:0]         coef;
  logic signed [16:0]  coef_s;
  logic signed [50:0]  prod_next;

  logic signed [36:0]  rnd3;
  logic signed [37:0]  sum3;
  logic signed [31:0]  clip3;
  logic                sat3;

  // Stage 1: differences and the first product
  always_comb begin
    if (op.is_edge) begin
      mul1_next  = 30'(op.cour);
      term1_next = 36'(op.v1) - 36'(op.cur) - 36'(op.v3) + 36'(op.v2);
      base1_next = 34'(op.cur) + 34'(op.v1) - 34'(op.v2);
    end else begin
      mul1_next  = 30'(op.cour) * 30'(op.cour);
      term1_next = 36'(op.v1) + 36'(op.v2) + 36'(op.v3) + 36'(op.v4)
                   - (36'(op.cur) <<< 2);
      base1_next = (34'(op.cur) <<< 1) - 34'(op.prev);
    end
  end

  always_ff @(posedge clk) begin
    mul1     <= mul1_next;
    term1    <= term1_next;
    base1    <= base1_next;
    is_edge1 <= op.is_edge;
    src1     <= op.is_src;
  end

  // Stage 2: scale the stencil term by the Courant coefficient
  assign coef      = is_edge1 ? 16'(mul1) : 16'((mul1 + 30'd16384) >> 15);
  assign coef_s    = signed'({1'b0, coef});
  assign prod_next = coef_s * term1;

  always_ff @(posedge clk) begin
    prod2 <= prod_next;
    base2 <= base1;
    src2  <= src1;
  end

  // Stage 3: round, add source, saturate
  assign rnd3 = 37'((prod2 + 51'sd16384) >>> 15);
  assign sum3 = 38'(base2) + 38'(rnd3) + (src2 ? 38'(amp) : 38'sd0);

  always_comb begin
    if (sum3 > 38'sd2147483647) begin
      clip3 = 32'sh7fffffff;
      sat3  = 1'b1;
    end else if (sum3 < -38'sd2147483648) begin
      clip3 = 32'sh80000000;
      sat3  = 1'b1;
    end else begin
      clip3 = 32'(sum3);
      sat3  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_value <= clip3;
    res_sat   <= sat3;
  end

  // Track valid through the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1q       <= 1'b0;
      v2q       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1q       <= op_valid;
      v2q       <= v1q;
      res_valid <= v2q;
    end
  end

endmodule

`default_nettype wire

>>> hdl/acoustic_wave_grid_step_top.sv
// Top level of the acoustic wave grid stepper: sequencer, cell memory and next memory.
// Depends on awgs_pkg, awgs_ram and awgs_calc.
//
// Usage:
//   req channel (valid/ready) carries one transaction: write a cell, read a
//   cell, or advance the whole grid by one time step. rsp channel returns one
//   transaction per request: read_value for a read, saturated for a step.
//   cfg_we/cfg_index/cfg_data write source_row (index 0) or source_col
//   (index 1); write them only while the block is idle.
// A step gathers each cell through the single read port of the cell memory
// (5 reads for an interior cell, 3 for an edge cell), then runs the
// arithmetic pipeline; after the last cell a copy pass writes the next memory
// into the cell memory, and then the response is delivered.
// Reset: a clearing pass zeroes all GRID_ROWS*GRID_COLS entries of the cell
// memory, one entry per cycle, while req_ready stays low.
// Stall: a finished result waits in the output register; one new request is
// accepted meanwhile and its result holds until the first one is taken.
`default_nettype none

module acoustic_wave_grid_step_top import awgs_pkg::*; #(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire req_t       req,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output rsp_t            rsp,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [5:0] cfg_data
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int KW    = $clog2(GRID_COLS);
  localparam int MW    = (RW > KW) ? RW : KW;
  localparam int XW    = ((MW > 6) ? MW : 6) + 1;
  localparam int MEMW  = $bits(cell_t);

  state_t state, state_next;

  logic [5:0]         source_row;
  logic [5:0]         source_col;

  logic [CW-1:0]      ca;
  logic               cp_v;
  logic [AW-1:0]      cp_a;
  logic [AW-1:0]      e;
  logic [RW-1:0]      r;
  logic [KW-1:0]      k;
  logic [2:0]         ph;
  logic [2:0]         slot_idx;
  logic signed [31:0] slot_cur  [5];
  logic signed [31:0] slot_prev [5];
  logic [14:0]        cour0;
  logic signed [31:0] amp_q;
  logic               sat_acc;
  logic signed [31:0] res_value;
  logic               res_sat;
  logic               rd_inside;

  logic               req_fire;
  logic               addr_ok;
  logic [AW-1:0]      cell_addr;
  logic               row_edge;
  logic               col_edge;
  logic               is_edge;
  logic               is_src;
  logic               last_cell;
  logic               copy_done;
  logic [2:0]         nr;
  logic [AW-1:0]      n1;
  logic [AW-1:0]      n2;
  logic [AW-1:0]      gather_addr;

  logic               main_we;
  logic [AW-1:0]      main_waddr;
  cell_t              main_wdata;
  logic [AW-1:0]      main_raddr;
  cell_t              main_rdata;
  logic               next_we;
  logic [31:0]        next_rdata;

  calc_op_t           op;
  logic               op_valid;
  logic               calc_res_valid;
  logic signed [31:0] calc_res_value;
  logic               calc_res_sat;

  assign req_fire = req_valid && req_ready;

  // Decode the addressed cell of a write or read
  assign addr_ok   = (XW'(req.cell_row) < XW'(GRID_ROWS)) &&
                     (XW'(req.cell_col) < XW'(GRID_COLS));
  assign cell_addr = AW'(AW'(req.cell_row) * AW'(GRID_COLS)) + AW'(req.cell_col);

  // Classify the swept cell and find its inward neighbors
  always_comb begin
    row_edge = ((r == '0) || (r == RW'(GRID_ROWS - 1))) &&
               !((r == RW'(GRID_ROWS - 1)) && (k == '0));
    col_edge = !row_edge && ((k == '0) || (k == KW'(GRID_COLS - 1)));
    is_edge  = row_edge || col_edge;
    if (row_edge && (r == '0)) begin
      n1 = e + AW'(GRID_COLS);
      n2 = e + AW'(2 * GRID_COLS);
    end else if (row_edge) begin
      n1 = e - AW'(GRID_COLS);
      n2 = e - AW'(2 * GRID_COLS);
    end else if (k == '0) begin
      n1 = e + AW'(1);
      n2 = e + AW'(2);
    end else begin
      n1 = e - AW'(1);
      n2 = e - AW'(2);
    end
    nr = is_edge ? 3'd3 : 3'd5;
    is_src = !is_edge && (XW'(r) == XW'(source_row)) && (XW'(k) == XW'(source_col));
    last_cell = (r == RW'(GRID_ROWS - 1)) && (k == KW'(GRID_COLS - 1));
  end

  // Pick the gather address for this phase
  always_comb begin
    case (ph)
      3'd0:    gather_addr = e;
      3'd1:    gather_addr = is_edge ? n1 : e + AW'(1);
      3'd2:    gather_addr = is_edge ? n2 : e - AW'(1);
      3'd3:    gather_addr = e + AW'(GRID_COLS);
      3'd4:    gather_addr = e - AW'(GRID_COLS);
      default: gather_addr = e;
    endcase
  end

  assign slot_idx  = ph - 3'd1;
  assign copy_done = (ca == CW'(CELLS));

  // Assemble the operands from the gathered slots
  always_comb begin
    op.is_edge = is_edge;
    op.is_src  = is_src;
    op.cur     = slot_cur[0];
    op.prev    = slot_prev[0];
    op.cour    = cour0;
    op.v1      = slot_cur[1];
    op.v2      = is_edge ? slot_prev[1] : slot_cur[2];
    op.v3      = is_edge ? slot_prev[2] : slot_cur[3];
    op.v4      = slot_cur[4];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (ca == CW'(CELLS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_fire) begin
          case (req.mode)
            MODE_STEP: state_next = S_GATHER;
            MODE_READ: state_next = S_RDWAIT;
            default:   state_next = S_FIN;
          endcase
        end
      end
      S_RDWAIT: state_next = S_FIN;
      S_GATHER: begin
        if (ph == nr) state_next = S_LAUNCH;
      end
      S_LAUNCH: state_next = S_CALC;
      S_CALC: begin
        if (calc_res_valid) state_next = last_cell ? S_COPY : S_GATHER;
      end
      S_COPY: begin
        if (copy_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory controls and handshake outputs
  always_comb begin
    req_ready  = 1'b0;
    op_valid   = 1'b0;
    main_we    = 1'b0;
    main_waddr = cell_addr;
    main_wdata = '0;
    main_raddr = gather_addr;
    next_we    = 1'b0;
    case (state)
      S_CLEAR: begin
        main_we    = 1'b1;
        main_waddr = ca[AW-1:0];
      end
      S_IDLE: begin
        req_ready  = 1'b1;
        main_raddr = cell_addr;
        main_we    = req_fire && (req.mode == MODE_WRITE) && addr_ok;
        main_wdata = '{cour: req.courant_number, prev: req.previous_value,
                       cur: req.current_value};
      end
      S_LAUNCH: op_valid = 1'b1;
      S_CALC:   next_we  = calc_res_valid;
      S_COPY: begin
        main_raddr = ca[AW-1:0];
        main_we    = cp_v;
        main_waddr = cp_a;
        main_wdata = '{cour: main_rdata.cour, prev: main_rdata.cur,
                       cur: next_rdata};
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_row <= SRC_ROW_RST;
      source_col <= SRC_COL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_ROW: source_row <= cfg_data;
        REG_SRC_COL: source_col <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sweep counter for clearing and copying, and the copy write pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      ca   <= '0;
      cp_v <= 1'b0;
    end else begin
      cp_v <= (state == S_COPY) && !copy_done;
      if ((state == S_CLEAR) || ((state == S_COPY) && !copy_done)) begin
        ca <= ca + CW'(1);
      end else if ((state == S_CALC) && calc_res_valid && last_cell) begin
        ca <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_a <= ca[AW-1:0];
  end

  // Cell walk, gather phase and step accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      ph      <= '0;
      e       <= '0;
      r       <= '0;
      k       <= '0;
      sat_acc <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire && (req.mode == MODE_STEP)) begin
            ph      <= '0;
            e       <= '0;
            r       <= '0;
            k       <= '0;
            sat_acc <= 1'b0;
          end
        end
        S_GATHER: begin
          ph <= (ph == nr) ? 3'd0 : ph + 3'd1;
        end
        S_CALC: begin
          if (calc_res_valid) begin
            sat_acc <= sat_acc | calc_res_sat;
            e       <= e + AW'(1);
            if (k == KW'(GRID_COLS - 1)) begin
              k <= '0;
              r <= r + RW'(1);
            end else begin
              k <= k + KW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Capture gathered words
  always_ff @(posedge clk) begin
    if ((state == S_GATHER) && (ph != 3'd0)) begin
      slot_cur[slot_idx]  <= main_rdata.cur;
      slot_prev[slot_idx] <= main_rdata.prev;
      if (ph == 3'd1) cour0 <= main_rdata.cour;
    end
  end

  // Hold the result of the current transaction
  always_ff @(posedge clk) begin
    if (req_fire) begin
      res_value <= '0;
      res_sat   <= 1'b0;
      rd_inside <= addr_ok;
      amp_q     <= req.source_amplitude;
    end else if (state == S_RDWAIT) begin
      res_value <= rd_inside ? main_rdata.cur : 32'sd0;
    end else if ((state == S_COPY) && copy_done) begin
      res_sat <= sat_acc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_FIN) && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && (!rsp_valid || rsp_ready)) begin
      rsp.read_value <= res_value;
      rsp.saturated  <= res_sat;
    end
  end

  awgs_ram #(
    .WIDTH (MEMW),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (main_we),
    .waddr (main_waddr),
    .wdata (main_wdata),
    .raddr (main_raddr),
    .rdata (main_rdata)
  );

  awgs_ram #(
    .WIDTH (32),
    .DEPTH (CELLS)
  ) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (e),
    .wdata (calc_res_value),
    .raddr (ca[AW-1:0]),
    .rdata (next_rdata)
  );

  awgs_calc u_calc (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op        (op),
    .amp       (amp_q),
    .res_valid (calc_res_valid),
    .res_value (calc_res_value),
    .res_sat   (calc_res_sat)
  );

  // A pipeline result only shows while the sequencer waits for it
  a_calc_in_step: assert property (@(posedge clk) disable iff (rst)
    calc_res_valid |-> (state == S_CALC))
    else $error("cell result outside of the step sequence");

  // The gather phase never runs past the interior read count
  a_ph_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_GATHER) |-> (ph <= 3'd5))
    else $error("gather phase out of range");

  // Only a step transaction can report saturation
  a_nonstep_nosat: assert property (@(posedge clk) disable iff (rst)
    (req_fire && (req.mode != MODE_STEP)) |=> !res_sat)
    else $error("saturation flagged on a non-step transaction");

  // A copy write comes in the cycle after a copy read
  a_copy_write: assert property (@(posedge clk) disable iff (rst)
    cp_v |-> ($past(state) == S_COPY))
    else $error("copy write without a copy read");

endmodule

`default_nettype wire
